// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl of the projection set-up block
// no dependencies; NO_ASSERTIONS removes every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/core/pps_pkg.sv =====
// shared types, constants and the arctangent table of the projection set-up
// no dependencies
package pps_pkg;

  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned DIV_STEPS    = 48;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] MAX_U31     = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIST_EQ = 2'd1,
    ST_SAT     = 2'd2
  } status_e;

  // one cordic rotation stage
  typedef struct packed {
    logic [33:0] c;
    logic [33:0] s;
    logic [32:0] z;
    logic [15:0] asp;
    logic [31:0] near_d;
    logic [31:0] far_d;
  } cor_stage_t;

  // four restoring dividers in lock step, quotient shifts into the low word
  typedef struct packed {
    logic [31:0] ys_den;
    logic [31:0] ys_rem;
    logic [47:0] ys_q;
    logic        ys_ovf;
    logic [47:0] xs_den;
    logic [47:0] xs_rem;
    logic [47:0] xs_q;
    logic        xs_ovf;
    logic [31:0] dsc_den;
    logic [31:0] dsc_rem;
    logic [47:0] dsc_q;
    logic        dsc_ovf;
    logic [32:0] dof_den;
    logic [32:0] dof_rem;
    logic [47:0] dof_q;
    logic        dof_ovf;
    logic        sin_zero;
    logic        cos_neg;
    logic        asp_zero;
    logic        dist_eq;
    logic        dist_neg;
  } div_stage_t;

  function automatic logic [29:0] atan_q30(input int unsigned idx);
    logic [29:0] v;
    case (idx)
      0:       v = 30'h3243F6A8;
      1:       v = 30'h1DAC6705;
      2:       v = 30'h0FADBAFC;
      3:       v = 30'h07F56EA6;
      4:       v = 30'h03FEAB76;
      5:       v = 30'h01FFD55B;
      6:       v = 30'h00FFFAAA;
      7:       v = 30'h007FFF55;
      8:       v = 30'h003FFFEA;
      9:       v = 30'h001FFFFD;
      10:      v = 30'h000FFFFF;
      11:      v = 30'h0007FFFF;
      12:      v = 30'h0003FFFF;
      13:      v = 30'h0001FFFF;
      14:      v = 30'h0000FFFF;
      15:      v = 30'h00007FFF;
      16:      v = 30'h00003FFF;
      17:      v = 30'h00001FFF;
      18:      v = 30'h00000FFF;
      19:      v = 30'h000007FF;
      20:      v = 30'h000003FF;
      21:      v = 30'h000001FF;
      22:      v = 30'h000000FF;
      23:      v = 30'h0000007F;
      24:      v = 30'h0000003F;
      25:      v = 30'h0000001F;
      26:      v = 30'h0000000F;
      27:      v = 30'h00000008;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/perspective_projection_setup.sv =====
// Perspective projection set-up: fov angle, aspect ratio and near/far
// distances in; x scale, y scale, depth scale, depth offset and status out.
// Both channels use valid/stall; a request is taken on an edge with valid
// high and stall low. One request per cycle is accepted, back to back,
// while in_stall_o is low. A request passes 28 cordic cells, 2 set-up
// stages, 48 divider cells (one quotient bit each) and the output register.
// Throughput is one result per cycle while the receiver takes results.
// When the receiver stalls, the result holds in the output register and
// the chain keeps moving while its last cell is empty; the chain freezes
// and in_stall_o rises only when a finished result would collide with the
// waiting one.
// Reset clears all valid bits; payload registers keep whatever they held.
// Status: near equal to far wins over saturation; x and y scale are still
// given in that case, depth values are zero.
// Depends on pps_pkg, pps_cordic_cell, pps_prep, pps_div_cell and
// assert_macros.svh.
`include "assert_macros.svh"

module perspective_projection_setup import pps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        fov_angle_i,
  input  logic [15:0]        aspect_ratio_i,
  input  logic [31:0]        near_dist_i,
  input  logic [31:0]        far_dist_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        x_scale_o,
  output logic [30:0]        y_scale_o,
  output logic signed [31:0] depth_scale_o,
  output logic signed [47:0] depth_offset_o,
  output logic [1:0]         status_o
);

  cor_stage_t cor_d [CORDIC_STEPS+1];
  logic       cor_v [CORDIC_STEPS+1];
  div_stage_t div_d [DIV_STEPS+1];
  logic       div_v [DIV_STEPS+1];

  logic        en, vlast;
  logic [30:0] z0;
  div_stage_t  fin;

  logic        ys_sat, xs_sat, dsc_sat, dof_sat, sat;
  logic [47:0] lim32, lim48;
  logic [31:0] dsc_mag;
  logic [47:0] dof_mag;
  logic [30:0] xs_d, ys_d;
  logic [31:0] dsc_d;
  logic [47:0] dof_d;
  status_e     st_d;

  logic        out_valid_q;
  logic [30:0] xs_q, ys_q;
  logic [31:0] dsc_q;
  logic [47:0] dof_q;
  status_e     st_q;

  assign vlast      = div_v[DIV_STEPS];
  assign en         = !(vlast && out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // start vector, folded by a quarter turn for wide angles
  always_comb begin
    z0 = {fov_angle_i, 15'd0};
    cor_d[0].asp    = aspect_ratio_i;
    cor_d[0].near_d = near_dist_i;
    cor_d[0].far_d  = far_dist_i;
    if (z0 > HALF_PI_Q30) begin
      cor_d[0].c = '0;
      cor_d[0].s = 34'sd1 <<< 30;
      cor_d[0].z = {2'b00, z0 - HALF_PI_Q30};
    end else begin
      cor_d[0].c = 34'sd1 <<< 30;
      cor_d[0].s = '0;
      cor_d[0].z = {2'b00, z0};
    end
  end
  assign cor_v[0] = in_valid_i;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pps_cordic_cell #(.STAGE(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (cor_v[i]),
      .data_i (cor_d[i]),
      .vld_o  (cor_v[i+1]),
      .data_o (cor_d[i+1])
    );
  end

  pps_prep u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cor_v[CORDIC_STEPS]),
    .data_i (cor_d[CORDIC_STEPS]),
    .vld_o  (div_v[0]),
    .data_o (div_d[0])
  );

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    pps_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (div_v[j]),
      .data_i (div_d[j]),
      .vld_o  (div_v[j+1]),
      .data_o (div_d[j+1])
    );
  end

  // clamp, sign and status
  always_comb begin
    fin    = div_d[DIV_STEPS];
    ys_sat = fin.ys_ovf || (fin.ys_q > {17'd0, MAX_U31});
    xs_sat = fin.xs_ovf || (fin.xs_q > {17'd0, MAX_U31});
    sat    = 1'b0;
    if (fin.sin_zero) begin
      ys_d = MAX_U31;
      xs_d = MAX_U31;
      sat  = 1'b1;
    end else if (fin.cos_neg) begin
      ys_d = '0;
      xs_d = '0;
      sat  = 1'b1;
    end else begin
      ys_d = ys_sat ? MAX_U31 : fin.ys_q[30:0];
      sat  = ys_sat;
      if (fin.asp_zero) begin
        xs_d = MAX_U31;
        sat  = 1'b1;
      end else begin
        xs_d = xs_sat ? MAX_U31 : fin.xs_q[30:0];
        sat  = sat || xs_sat;
      end
    end

    lim32   = fin.dist_neg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
    lim48   = fin.dist_neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    dsc_sat = fin.dsc_ovf || (fin.dsc_q > lim32);
    dof_sat = fin.dof_ovf || (fin.dof_q > lim48);
    dsc_mag = dsc_sat ? lim32[31:0] : fin.dsc_q[31:0];
    dof_mag = dof_sat ? lim48 : fin.dof_q;

    if (fin.dist_eq) begin
      dsc_d = '0;
      dof_d = '0;
      st_d  = ST_DIST_EQ;
    end else begin
      dsc_d = fin.dist_neg ? 32'd0 - dsc_mag : dsc_mag;
      dof_d = fin.dist_neg ? 48'd0 - dof_mag : dof_mag;
      st_d  = (sat || dsc_sat || dof_sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= vlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      xs_q  <= xs_d;
      ys_q  <= ys_d;
      dsc_q <= dsc_d;
      dof_q <= dof_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign x_scale_o      = xs_q;
  assign y_scale_o      = ys_q;
  assign depth_scale_o  = dsc_q;
  assign depth_offset_o = dof_q;
  assign status_o       = st_q;

  `ASSERT_PROP(a_last_reaches_out, clk_i, rst_ni, (en && vlast) |=> out_valid_q)
  `ASSERT_PROP(a_taken_empties, clk_i, rst_ni, (out_valid_q && !out_stall_i && !vlast) |=> !out_valid_q)
  `ASSERT_NEVER(a_eq_depth_zero, clk_i, rst_ni, out_valid_o && (st_q == ST_DIST_EQ) && ((dsc_q != '0) || (dof_q != '0)))

endmodule

// ===== rtl/core/pps_cordic_cell.sv =====
// one rotation-mode cordic stage with its registers
// depends on pps_pkg
module pps_cordic_cell import pps_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  cor_stage_t data_i,
  output logic       vld_o,
  output cor_stage_t data_o
);

  localparam logic [29:0] ATAN = atan_q30(STAGE);

  logic signed [33:0] c, s, dc, ds;
  logic signed [32:0] z, at;
  cor_stage_t         data_d, data_q;
  logic               vld_q;

  always_comb begin
    c  = data_i.c;
    s  = data_i.s;
    z  = data_i.z;
    dc = s >>> STAGE;
    ds = c >>> STAGE;
    at = signed'({3'b000, ATAN});
    data_d = data_i;
    if (!z[32]) begin
      data_d.c = c - dc;
      data_d.s = s + ds;
      data_d.z = z - at;
    end else begin
      data_d.c = c + dc;
      data_d.s = s - ds;
      data_d.z = z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== rtl/core/pps_prep.sv =====
// two register stages between the cordic and the dividers: products,
// distance difference, then numerators and overflow pre-checks
// depends on pps_pkg
module pps_prep import pps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  cor_stage_t data_i,
  output logic       vld_o,
  output div_stage_t data_o
);

  typedef struct packed {
    logic [30:0] cu;
    logic [31:0] su;
    logic [47:0] prod_x;
    logic [63:0] prod_d;
    logic [31:0] diff;
    logic [32:0] sum;
    logic        sin_zero;
    logic        cos_neg;
    logic        asp_zero;
    logic        dist_eq;
    logic        dist_neg;
  } prep_t;

  prep_t      p_d, p_q;
  div_stage_t div_d, div_q;
  logic       vld1_q, vld2_q;
  logic [47:0] num_y;
  logic [55:0] num_x;
  logic [49:0] num_s;
  logic [66:0] num_o;

  always_comb begin
    p_d.cu       = data_i.c[30:0];
    p_d.su       = data_i.s[31:0];
    p_d.prod_x   = {16'd0, data_i.s[31:0]} * {32'd0, data_i.asp};
    p_d.prod_d   = {32'd0, data_i.far_d} * {32'd0, data_i.near_d};
    p_d.dist_neg = data_i.far_d > data_i.near_d;
    p_d.dist_eq  = data_i.far_d == data_i.near_d;
    p_d.diff     = p_d.dist_neg ? data_i.far_d - data_i.near_d
                                : data_i.near_d - data_i.far_d;
    p_d.sum      = {1'b0, data_i.far_d} + {1'b0, data_i.near_d};
    p_d.sin_zero = data_i.s[33] || (data_i.s == '0);
    p_d.cos_neg  = data_i.c[33];
    p_d.asp_zero = data_i.asp == '0;
  end

  // rounding terms folded into the numerators, quotients limited to 48 bits
  always_comb begin
    num_y = {1'b0, p_q.cu, 16'd0} + {17'd0, p_q.su[31:1]};
    num_x = {1'b0, p_q.cu, 24'd0} + {9'd0, p_q.prod_x[47:1]};
    num_s = {1'b0, p_q.sum, 16'd0} + {19'd0, p_q.diff[31:1]};
    num_o = {1'b0, p_q.prod_d, 2'b00} + {35'd0, p_q.diff};

    div_d.ys_den  = p_q.su;
    div_d.ys_rem  = '0;
    div_d.ys_q    = num_y;
    div_d.ys_ovf  = 1'b0;
    div_d.xs_den  = p_q.prod_x;
    div_d.xs_rem  = {40'd0, num_x[55:48]};
    div_d.xs_q    = num_x[47:0];
    div_d.xs_ovf  = {40'd0, num_x[55:48]} >= p_q.prod_x;
    div_d.dsc_den = p_q.diff;
    div_d.dsc_rem = {30'd0, num_s[49:48]};
    div_d.dsc_q   = num_s[47:0];
    div_d.dsc_ovf = {30'd0, num_s[49:48]} >= p_q.diff;
    div_d.dof_den = {p_q.diff, 1'b0};
    div_d.dof_rem = {14'd0, num_o[66:48]};
    div_d.dof_q   = num_o[47:0];
    div_d.dof_ovf = {14'd0, num_o[66:48]} >= {p_q.diff, 1'b0};
    div_d.sin_zero = p_q.sin_zero;
    div_d.cos_neg  = p_q.cos_neg;
    div_d.asp_zero = p_q.asp_zero;
    div_d.dist_eq  = p_q.dist_eq;
    div_d.dist_neg = p_q.dist_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      div_q <= div_d;
    end
  end

  assign vld_o  = vld2_q;
  assign data_o = div_q;

endmodule

// ===== rtl/core/pps_div_cell.sv =====
// one restoring division step for all four dividers, with its registers
// depends on pps_pkg
module pps_div_cell import pps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       vld_i,
  input  div_stage_t data_i,
  output logic       vld_o,
  output div_stage_t data_o
);

  // returns {remainder, quotient word}
  function automatic logic [95:0] div_step(input logic [47:0] rem,
                                           input logic [47:0] qw,
                                           input logic [47:0] den);
    logic [48:0] t, r;
    logic        ge;
    t  = {rem, qw[47]};
    ge = t >= {1'b0, den};
    r  = ge ? t - {1'b0, den} : t;
    return {r[47:0], qw[46:0], ge};
  endfunction

  logic [95:0] st_y, st_x, st_s, st_o;
  div_stage_t  data_d, data_q;
  logic        vld_q;

  always_comb begin
    st_y = div_step({16'd0, data_i.ys_rem}, data_i.ys_q, {16'd0, data_i.ys_den});
    st_x = div_step(data_i.xs_rem, data_i.xs_q, data_i.xs_den);
    st_s = div_step({16'd0, data_i.dsc_rem}, data_i.dsc_q, {16'd0, data_i.dsc_den});
    st_o = div_step({15'd0, data_i.dof_rem}, data_i.dof_q, {15'd0, data_i.dof_den});
    data_d         = data_i;
    data_d.ys_rem  = st_y[79:48];
    data_d.ys_q    = st_y[47:0];
    data_d.xs_rem  = st_x[95:48];
    data_d.xs_q    = st_x[47:0];
    data_d.dsc_rem = st_s[79:48];
    data_d.dsc_q   = st_s[47:0];
    data_d.dof_rem = st_o[80:48];
    data_d.dof_q   = st_o[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
